### hw/rtl/wcn_pkg.sv
// Shared types, constants and helper functions for the cellular noise block.
// No dependencies; every other file of the block depends on this package.
`default_nettype none
package wcn_pkg;
    localparam logic [31:0] HASH_MUL_X = 32'h1B873593;
    localparam logic [31:0] HASH_MUL_Y = 32'h19088711;
    localparam logic [31:0] HASH_MUL_Z = 32'hB2D05E13;
    localparam logic [31:0] HASH_MIX   = 32'hCC9E2D51;
    localparam logic [3:0]  MAX_CELL_LOG = 4'd14;
    localparam logic [2:0]  MAX_DOTS_LOG = 3'd4;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SEED        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_LOG    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOTS_LOG    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_PLANE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_SPACE = 3'd4;

    typedef struct packed {
        logic        func;
        logic [31:0] coord_x;
        logic [31:0] coord_y;
        logic [31:0] coord_z;
    } wcn_in_t;

    typedef struct packed {
        logic [31:0] noise_value;
        logic        saturated;
    } wcn_out_t;

    // Datapath operations issued by the controller, one per cycle.
    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_NOP    = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd1; // latch item, set best to all ones
    localparam logic [OP_W-1:0] OP_HSUM   = 3'd2; // cell hash: multiply-add term
    localparam logic [OP_W-1:0] OP_HMIX   = 3'd3; // cell hash: shift and mix
    localparam logic [OP_W-1:0] OP_DOT    = 3'd4; // xorshift, place dot, diffs
    localparam logic [OP_W-1:0] OP_DIST   = 3'd5; // square one axis, accumulate
    localparam logic [OP_W-1:0] OP_SCALE  = 3'd6; // final scale multiply
    localparam logic [OP_W-1:0] OP_RESULT = 3'd7; // saturate into output reg

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [1:0]      term;   // hash term or distance axis
        logic [1:0]      ox;     // neighbor offset code: 0 -> -1, 1 -> 0, 2 -> +1
        logic [1:0]      oy;
        logic [1:0]      oz;
        logic            first;  // first axis of a dot distance
        logic            last;   // last axis of a dot distance
    } wcn_cmd_t;

    typedef struct packed {
        logic       space;
        logic [4:0] dot_count; // 1 to 16
    } wcn_stat_t;

    function automatic logic [31:0] xs32(input logic [31:0] v);
        logic [31:0] a;
        logic [31:0] b;
        a = v ^ (v << 13);
        b = a ^ (a >> 17);
        return b ^ (b << 5);
    endfunction
endpackage
`default_nettype wire

### hw/rtl/worley_cell_noise.sv
// Cellular noise block top level: configuration registers, controller, datapath.
// Depends on wcn_pkg, wcn_ctrl and wcn_dp.
// A search covers 9 cells (2D) or 27 (3D), 1 to 16 dots per cell, 2 or 3 axes.
// One transaction at a time; the next accept can come in the cycle after the result loads.
// Reset is asynchronous active low and restores the register defaults.
`default_nettype none
module worley_cell_noise (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire wcn_pkg::wcn_in_t              in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output wcn_pkg::wcn_out_t                  out_data,
    input  wire logic                          cfg_we,
    input  wire logic [wcn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);
    import wcn_pkg::*;

    logic [31:0] seed_reg;
    logic [3:0]  cell_log_reg;
    logic [2:0]  dots_log_reg;
    logic [31:0] scale_plane_reg;
    logic [31:0] scale_space_reg;
    wcn_cmd_t    cmd;
    wcn_stat_t   stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= 32'd0;
            cell_log_reg <= 4'd8;
            dots_log_reg <= 3'd2;
            scale_plane_reg <= 32'd1;
            scale_space_reg <= 32'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SEED:        seed_reg <= cfg_data;
                REG_CELL_LOG:    cell_log_reg <= cfg_data[3:0];
                REG_DOTS_LOG:    dots_log_reg <= cfg_data[2:0];
                REG_SCALE_PLANE: scale_plane_reg <= cfg_data;
                REG_SCALE_SPACE: scale_space_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    wcn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    wcn_dp u_dp (
        .clk         (clk),
        .cmd         (cmd),
        .in_item     (in_data),
        .seed        (seed_reg),
        .cell_log    (cell_log_reg),
        .dots_log    (dots_log_reg),
        .scale_plane (scale_plane_reg),
        .scale_space (scale_space_reg),
        .stat        (stat),
        .out_item    (out_data)
    );
endmodule
`default_nettype wire

### hw/rtl/wcn_ctrl.sv
// Controller for the cellular noise block: sequences cells, hash steps and dots.
// Depends on wcn_pkg; drives wcn_dp through a command struct.
`default_nettype none
module wcn_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire wcn_pkg::wcn_stat_t stat,
    output wcn_pkg::wcn_cmd_t      cmd
);
    import wcn_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_HSUM  = 3'd1;
    localparam logic [2:0] S_HMIX  = 3'd2;
    localparam logic [2:0] S_DOT   = 3'd3;
    localparam logic [2:0] S_DIST  = 3'd4;
    localparam logic [2:0] S_SCALE = 3'd5;
    localparam logic [2:0] S_RES   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [1:0] term_reg, term_next;
    logic [1:0] ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic [4:0] dot_reg, dot_next;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] last_axis;
    logic       last_cell;

    assign last_axis = stat.space ? 2'd2 : 2'd1;
    assign last_cell = (ox_reg == 2'd2) && (oy_reg == 2'd2)
                       && (!stat.space || oz_reg == 2'd2);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        term_next = term_reg;
        ox_next = ox_reg;
        oy_next = oy_reg;
        oz_next = oz_reg;
        dot_next = dot_reg;
        out_valid_next = out_valid_reg;
        cmd = '0;
        cmd.op = OP_NOP;
        cmd.term = term_reg;
        cmd.ox = ox_reg;
        cmd.oy = oy_reg;
        cmd.oz = oz_reg;
        cmd.first = (term_reg == 2'd0);
        cmd.last = (term_reg == last_axis);
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                    state_next = S_HSUM;
                    term_next = 2'd0;
                    ox_next = 2'd0;
                    oy_next = 2'd0;
                    oz_next = 2'd0;
                end
            end
            S_HSUM:
            begin
                cmd.op = OP_HSUM;
                if (term_reg == 2'd2)
                begin
                    state_next = S_HMIX;
                    term_next = 2'd0;
                end
                else
                begin
                    term_next = term_reg + 2'd1;
                end
            end
            S_HMIX:
            begin
                cmd.op = OP_HMIX;
                state_next = S_DOT;
                dot_next = 5'd0;
            end
            S_DOT:
            begin
                cmd.op = OP_DOT;
                state_next = S_DIST;
                term_next = 2'd0;
            end
            S_DIST:
            begin
                cmd.op = OP_DIST;
                if (term_reg == last_axis)
                begin
                    term_next = 2'd0;
                    if (dot_reg + 5'd1 == stat.dot_count)
                    begin
                        if (last_cell)
                        begin
                            state_next = S_SCALE;
                        end
                        else
                        begin
                            state_next = S_HSUM;
                            if (ox_reg != 2'd2)
                            begin
                                ox_next = ox_reg + 2'd1;
                            end
                            else
                            begin
                                ox_next = 2'd0;
                                if (oy_reg != 2'd2)
                                begin
                                    oy_next = oy_reg + 2'd1;
                                end
                                else
                                begin
                                    oy_next = 2'd0;
                                    oz_next = oz_reg + 2'd1;
                                end
                            end
                        end
                    end
                    else
                    begin
                        dot_next = dot_reg + 5'd1;
                        state_next = S_DOT;
                    end
                end
                else
                begin
                    term_next = term_reg + 2'd1;
                end
            end
            S_SCALE:
            begin
                cmd.op = OP_SCALE;
                state_next = S_RES;
            end
            S_RES:
            begin
                // Waits until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op = OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            term_reg <= '0;
            ox_reg <= '0;
            oy_reg <= '0;
            oz_reg <= '0;
            dot_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg <= term_next;
            ox_reg <= ox_next;
            oy_reg <= oy_next;
            oz_reg <= oz_next;
            dot_reg <= dot_next;
            out_valid_reg <= out_valid_next;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/wcn_dp.sv
// Datapath for the cellular noise block: hash, dot placement, distance, scale.
// Depends on wcn_pkg; one shared 32x32 multiplier serves every product.
`default_nettype none
module wcn_dp (
    input  wire logic              clk,
    input  wire wcn_pkg::wcn_cmd_t cmd,
    input  wire wcn_pkg::wcn_in_t  in_item,
    input  wire logic [31:0]       seed,
    input  wire logic [3:0]        cell_log,
    input  wire logic [2:0]        dots_log,
    input  wire logic [31:0]       scale_plane,
    input  wire logic [31:0]       scale_space,
    output wcn_pkg::wcn_stat_t     stat,
    output wcn_pkg::wcn_out_t      out_item
);
    import wcn_pkg::*;

    logic        space_reg;
    logic [31:0] x_reg, y_reg, z_reg;
    logic [3:0]  gp_reg;
    logic [3:0]  mask_reg;
    logic [31:0] h_reg, h_next;
    logic [4:0]  count_reg;
    logic [31:0] best_reg;
    logic [31:0] acc_reg;
    logic [15:0] dx_reg, dy_reg, dz_reg; // signed differences, |d| < 2^15
    logic [63:0] prod_reg;
    logic [31:0] ma, mb;
    logic [63:0] mprod;
    logic [31:0] cell_base, cell_idx;
    logic [1:0]  off_code;
    logic [31:0] cellmask;
    logic [16:0] edge_len;
    logic [16:0] px, py, pz, fx, fy, fz;
    logic [16:0] sx, sy, sz;
    logic [15:0] sq_in;
    logic [15:0] sq_abs;
    logic [32:0] acc_sum;
    logic [31:0] dist_sum;
    logic [2:0]  dl;

    assign dl = (dots_log > MAX_DOTS_LOG) ? MAX_DOTS_LOG : dots_log;
    assign cellmask = (32'd1 << gp_reg) - 32'd1;
    assign edge_len = 17'd1 << gp_reg;
    assign stat.space = space_reg;
    assign stat.dot_count = count_reg;

    // Cell index and its multiplier for the current hash term.
    always_comb
    begin
        case (cmd.term)
            2'd0:
            begin
                cell_base = x_reg >> gp_reg;
                off_code = cmd.ox;
                mb = HASH_MUL_X;
            end
            2'd1:
            begin
                cell_base = y_reg >> gp_reg;
                off_code = cmd.oy;
                mb = HASH_MUL_Y;
            end
            default:
            begin
                cell_base = z_reg >> gp_reg;
                off_code = cmd.oz;
                mb = HASH_MUL_Z;
            end
        endcase
        cell_idx = cell_base + {{30{off_code == 2'd0}}, off_code == 2'd0 ? 2'b11 :
                   (off_code == 2'd2 ? 2'b01 : 2'b00)};
        if (cmd.term == 2'd2 && !space_reg)
        begin
            cell_idx = '0;
        end
    end

    // Axis difference for squaring: pick the axis, take magnitude.
    always_comb
    begin
        case (cmd.term)
            2'd0: sq_in = dx_reg;
            2'd1: sq_in = dy_reg;
            default: sq_in = dz_reg;
        endcase
        sq_abs = sq_in[15] ? (16'd0 - sq_in) : sq_in;
    end

    always_comb
    begin
        ma = cell_idx;
        case (cmd.op)
            OP_HMIX:
            begin
                ma = h_reg ^ (h_reg >> 5);
            end
            OP_DIST:
            begin
                ma = {16'd0, sq_abs};
            end
            OP_SCALE:
            begin
                ma = best_reg;
            end
            default:
            begin
                ma = cell_idx;
            end
        endcase
    end

    always_comb
    begin
        logic [31:0] mbx;
        mbx = mb;
        case (cmd.op)
            OP_HMIX:  mbx = HASH_MIX;
            OP_DIST:  mbx = {16'd0, sq_abs};
            OP_SCALE: mbx = space_reg ? scale_space : scale_plane;
            default:  mbx = mb;
        endcase
        mprod = {32'd0, ma} * {32'd0, mbx};
    end

    // Dot position and offset of the point relative to the examined cell.
    always_comb
    begin
        h_next = xs32(h_reg);
        if (space_reg)
        begin
            px = 17'(({22'd0, h_next[9:0]} << gp_reg) >> 10);
            py = 17'(({22'd0, h_next[19:10]} << gp_reg) >> 10);
            pz = 17'(({22'd0, h_next[29:20]} << gp_reg) >> 10);
        end
        else
        begin
            px = 17'(({15'd0, h_next[15:0]} << gp_reg) >> 16);
            py = 17'(({15'd0, h_next[31:16]} << gp_reg) >> 16);
            pz = '0;
        end
        fx = {1'b0, x_reg[15:0] & cellmask[15:0]};
        fy = {1'b0, y_reg[15:0] & cellmask[15:0]};
        fz = space_reg ? {1'b0, z_reg[15:0] & cellmask[15:0]} : 17'd0;
        // Offset relative to cell (o - 1): f - (o-1)*edge.
        sx = fx - ((cmd.ox == 2'd0) ? (17'd0 - edge_len) :
                   ((cmd.ox == 2'd2) ? edge_len : 17'd0));
        sy = fy - ((cmd.oy == 2'd0) ? (17'd0 - edge_len) :
                   ((cmd.oy == 2'd2) ? edge_len : 17'd0));
        sz = fz - (!space_reg ? 17'd0 : ((cmd.oz == 2'd0) ? (17'd0 - edge_len) :
                   ((cmd.oz == 2'd2) ? edge_len : 17'd0)));
    end

    assign acc_sum = (cmd.first ? 33'd0 : {1'b0, acc_reg}) + {1'b0, mprod[31:0]};
    assign dist_sum = acc_sum[31:0];

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                space_reg <= in_item.func;
                x_reg <= in_item.coord_x;
                y_reg <= in_item.coord_y;
                z_reg <= in_item.coord_z;
                gp_reg <= (cell_log > MAX_CELL_LOG) ? MAX_CELL_LOG : cell_log;
                mask_reg <= 4'((5'd1 << dl) - 5'd1);
                best_reg <= 32'hFFFFFFFF;
                h_reg <= seed;
                acc_reg <= seed;
            end
            OP_HSUM:
            begin
                if (cmd.term == 2'd0)
                begin
                    h_reg <= seed + mprod[31:0];
                end
                else
                begin
                    h_reg <= h_reg + mprod[31:0];
                end
            end
            OP_HMIX:
            begin
                h_reg <= mprod[31:0];
                // The dot count comes from the mixed hash before any xorshift step.
                count_reg <= {1'b0, mask_reg & mprod[18:15]} + 5'd1;
            end
            OP_DOT:
            begin
                h_reg <= h_next;
                dx_reg <= 16'(px - sx);
                dy_reg <= 16'(py - sy);
                dz_reg <= 16'(pz - sz);
            end
            OP_DIST:
            begin
                acc_reg <= dist_sum;
                if (cmd.last && dist_sum < best_reg)
                begin
                    best_reg <= dist_sum;
                end
            end
            OP_SCALE:
            begin
                prod_reg <= mprod;
            end
            OP_RESULT:
            begin
                if (prod_reg >= 64'hFFFFFFFF)
                begin
                    out_item.noise_value <= 32'hFFFFFFFF;
                    out_item.saturated <= 1'b1;
                end
                else
                begin
                    out_item.noise_value <= prod_reg[31:0];
                    out_item.saturated <= 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end
endmodule
`default_nettype wire

### hw/rtl/wcn_checker.sv
// Port-level checker for the cellular noise block, bound to the top level.
// Depends on wcn_pkg for the payload types.
`default_nettype none
module wcn_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire wcn_pkg::wcn_out_t out_data
);
    // A held result keeps its value until the transaction completes.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // The saturation flag matches an all-ones value.
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.saturated == (out_data.noise_value == 32'hFFFFFFFF)))
        else $error("saturation flag mismatch");

    // An item accepted while no result is pending is not followed by a result in the next cycle.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result too early");

    // Input is not taken again right after an accept.
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item accepted while busy");
endmodule

bind worley_cell_noise wcn_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire
